@@ rtl/flame_stencil_update_top_defines.svh @@
// Assertion macros for the flame stencil RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef FLAME_STENCIL_UPDATE_TOP_DEFINES_SVH
`define FLAME_STENCIL_UPDATE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FSU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fsu_pkg.sv @@
// Package for the flame stencil update block: codes, widths, reset values,
// stencil weights and the final scaling of the weighted sum. No dependencies.
`default_nettype none

package fsu_pkg;

    localparam int MAX_ROWS_DEF = 32;
    localparam int MAX_COLS_DEF = 128;

    localparam int OP_W    = 2;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int VAL_W   = 4;
    localparam int NOISE_W = 2;
    localparam int ROWS_W  = 6;
    localparam int COLS_W  = 8;
    localparam int REG_IDX_W  = 2;
    localparam int REG_DATA_W = 8;

    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd1;
    localparam logic [OP_W-1:0] OP_SWAP    = 2'd2;
    localparam logic [OP_W-1:0] OP_READ    = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_ROWS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_COLS = 2'd1;

    localparam logic [ROWS_W-1:0] ROWS_RESET = 6'd29;
    localparam logic [COLS_W-1:0] COLS_RESET = 8'd117;
    localparam logic [VAL_W-1:0]  LEVEL_MAX  = 4'd9;
    localparam logic [VAL_W-1:0]  LEVELS     = 4'd10;
    localparam logic [5:0]        RECIP_NINE = 6'd57;

    typedef logic signed [2:0] weight_t;
    typedef logic signed [7:0] sum_t;

    function automatic weight_t fsu_weight(input logic [1:0] dr, input logic [1:0] dc);
        weight_t w;
        case ({dr, dc})
            4'b0000: w = -3'sd1;
            4'b0001: w = 3'sd1;
            4'b0010: w = -3'sd1;
            4'b0100: w = 3'sd1;
            4'b0101: w = 3'sd2;
            4'b0110: w = 3'sd1;
            4'b1000: w = 3'sd2;
            4'b1001: w = 3'sd3;
            4'b1010: w = 3'sd2;
            default: w = 3'sd0;
        endcase
        return w;
    endfunction

    // Subtract noise from a positive sum, divide by nine, wrap to the level range.
    function automatic logic [VAL_W-1:0] fsu_finish(input sum_t sum,
                                                    input logic [NOISE_W-1:0] noise);
        sum_t             s;
        logic [12:0]      prod;
        logic [VAL_W-1:0] q;
        s = sum;
        if (s > 8'sd0)
            s = s - $signed({6'b000000, noise});
        prod = 13'(s[6:0]) * 13'(RECIP_NINE);
        q    = prod[12:9];
        if (s <= 8'sd0)
            q = '0;
        else if (q >= LEVELS)
            q = q - LEVELS;
        return q;
    endfunction

endpackage

`default_nettype wire

@@ rtl/fsu_if.sv @@
// Channel interfaces of the flame stencil update block: item, result and
// register write. Depends on fsu_pkg for field widths.
`default_nettype none

interface fsu_item_if;
    logic                          valid;
    logic                          ready;
    logic [fsu_pkg::OP_W-1:0]      op;
    logic [fsu_pkg::ROW_W-1:0]     row;
    logic [fsu_pkg::COL_W-1:0]     col;
    logic [fsu_pkg::VAL_W-1:0]     write_value;
    logic [fsu_pkg::NOISE_W-1:0]   noise;

    modport source (output valid, op, row, col, write_value, noise, input ready);
    modport sink   (input valid, op, row, col, write_value, noise, output ready);
endinterface

interface fsu_result_if;
    logic                      valid;
    logic                      ready;
    logic [fsu_pkg::VAL_W-1:0] cell_value;

    modport source (output valid, cell_value, input ready);
    modport sink   (input valid, cell_value, output ready);
endinterface

interface fsu_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fsu_pkg::REG_IDX_W-1:0]  reg_index;
    logic [fsu_pkg::REG_DATA_W-1:0] reg_data;

    modport source (output valid, reg_index, reg_data, input ready);
    modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

`default_nettype wire

@@ rtl/fsu_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module fsu_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/flame_stencil_update_top.sv @@
// Flame stencil update: ping-pong intensity frames with a 3x3 weighted stencil.
// Depends on fsu_pkg, fsu_if.sv, fsu_ram and flame_stencil_update_top_defines.svh.
//
// Usage:
//   item   : one word per operation (write, compute, swap, read).
//   result : one word per item, cell_value, in item order.
//   cfg    : register writes (active rows, active columns), always ready;
//            write only while no item is in flight.
// Both frame banks live in one single-port RAM of 2*MAX_ROWS*MAX_COLS cells.
// After reset the block sweeps the RAM to zero, one cell per cycle;
// item.ready stays low meanwhile.
// One item is worked at a time. Steps from accept to result valid:
//   write stores the cell, swap flips the bank, read fetches the cell, compute does
//   nine neighbour reads through the single RAM port, one drain, one scale-and-store;
//   each item then hands over its result in FIN.
// A finished result sits in the output register; the next item is accepted
// while it waits. If the receiver stalls, the following result holds in the
// engine and no further item is accepted until the output register frees.
`default_nettype none
`include "flame_stencil_update_top_defines.svh"

module flame_stencil_update_top #(
    parameter int MAX_ROWS = fsu_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = fsu_pkg::MAX_COLS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    fsu_cfg_if.sink           cfg,
    fsu_item_if.sink          item,
    fsu_result_if.source      result
);

    localparam int BANK_CELLS = MAX_ROWS * MAX_COLS;
    localparam int DEPTH      = 2 * BANK_CELLS;
    localparam int AW         = $clog2(DEPTH);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_WR    = 4'd2;
    localparam logic [3:0] ST_RD    = 4'd3;
    localparam logic [3:0] ST_RDW   = 4'd4;
    localparam logic [3:0] ST_NB    = 4'd5;
    localparam logic [3:0] ST_ACC   = 4'd6;
    localparam logic [3:0] ST_CALC  = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;

    logic [3:0] state_reg, state_next;

    logic [fsu_pkg::ROWS_W-1:0]  rows_reg;
    logic [fsu_pkg::COLS_W-1:0]  cols_reg;
    logic                        cur_bank_reg;
    logic [AW-1:0]               clr_cnt_reg;

    logic [fsu_pkg::ROW_W-1:0]   r_reg;
    logic [fsu_pkg::COL_W-1:0]   c_reg;
    logic [fsu_pkg::VAL_W-1:0]   wv_reg;
    logic [fsu_pkg::NOISE_W-1:0] noise_reg;
    logic                        inside_reg;
    logic [1:0]                  dr_reg;
    logic [1:0]                  dc_reg;
    logic                        tap_valid_reg;
    fsu_pkg::weight_t            tap_w_reg;
    fsu_pkg::sum_t               sum_reg;
    logic [fsu_pkg::VAL_W-1:0]   res_reg;
    logic                        out_valid_reg;
    logic [fsu_pkg::VAL_W-1:0]   cell_value_reg;

    logic                        item_fire;
    logic                        out_load;
    logic [fsu_pkg::VAL_W-1:0]   wv_sat;
    logic                        in_frame;
    logic [5:0]                  nb_row;
    logic [7:0]                  nb_col;
    logic                        nb_valid;
    fsu_pkg::sum_t               tap_prod;
    logic [fsu_pkg::VAL_W-1:0]   calc_value;
    logic [AW-1:0]               cell_addr;
    logic [AW-1:0]               nb_addr;
    logic [AW-1:0]               calc_addr;

    logic                        ram_we;
    logic [AW-1:0]               ram_addr;
    logic [fsu_pkg::VAL_W-1:0]   ram_wdata;
    logic [fsu_pkg::VAL_W-1:0]   ram_rdata;

    function automatic logic [AW-1:0] addr_of(input logic bank, input logic [5:0] rr,
                                              input logic [7:0] cc);
        logic [AW-1:0] base;
        base = bank ? AW'(BANK_CELLS) : '0;
        return base + AW'(rr) * AW'(MAX_COLS) + AW'(cc);
    endfunction

    assign item_fire = item.valid && item.ready;
    assign item.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign out_load = (state_reg == ST_FIN) && (!out_valid_reg || result.ready);
    assign result.valid = out_valid_reg;
    assign result.cell_value = cell_value_reg;

    assign wv_sat   = (item.write_value > fsu_pkg::LEVEL_MAX) ? fsu_pkg::LEVEL_MAX
                                                              : item.write_value;
    assign in_frame = (32'(item.row) < MAX_ROWS) && (32'(item.col) < MAX_COLS);

    assign nb_row = {1'b0, r_reg} + 6'(dr_reg) - 6'd1;
    assign nb_col = {1'b0, c_reg} + 8'(dc_reg) - 8'd1;
    assign nb_valid = !(r_reg == '0 && dr_reg == 2'd0) && !(c_reg == '0 && dc_reg == 2'd0)
                      && (nb_row < rows_reg) && (32'(nb_row) < MAX_ROWS)
                      && (nb_col < cols_reg) && (32'(nb_col) < MAX_COLS);

    assign tap_prod   = $signed({4'b0000, ram_rdata}) * $signed({{5{tap_w_reg[2]}}, tap_w_reg});
    assign calc_value = fsu_pkg::fsu_finish(sum_reg, noise_reg);

    assign cell_addr = addr_of(cur_bank_reg, {1'b0, r_reg}, {1'b0, c_reg});
    assign calc_addr = addr_of(!cur_bank_reg, {1'b0, r_reg}, {1'b0, c_reg});
    assign nb_addr   = addr_of(cur_bank_reg, nb_row, nb_col);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = cell_addr;
        ram_wdata = wv_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = '0;
            end
            ST_WR:
            begin
                ram_we = inside_reg;
            end
            ST_NB:
            begin
                ram_addr = nb_addr;
            end
            ST_CALC:
            begin
                ram_we    = 1'b1;
                ram_addr  = calc_addr;
                ram_wdata = calc_value;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    case (item.op)
                        fsu_pkg::OP_WRITE:   state_next = ST_WR;
                        fsu_pkg::OP_COMPUTE: state_next = in_frame ? ST_NB : ST_FIN;
                        fsu_pkg::OP_READ:    state_next = in_frame ? ST_RD : ST_FIN;
                        default:             state_next = ST_FIN;
                    endcase
                end
            end
            ST_WR:   state_next = ST_FIN;
            ST_RD:   state_next = ST_RDW;
            ST_RDW:  state_next = ST_FIN;
            ST_NB:
            begin
                if (dr_reg == 2'd2 && dc_reg == 2'd2)
                    state_next = ST_ACC;
            end
            ST_ACC:  state_next = ST_CALC;
            ST_CALC: state_next = ST_FIN;
            ST_FIN:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            rows_reg      <= fsu_pkg::ROWS_RESET;
            cols_reg      <= fsu_pkg::COLS_RESET;
            cur_bank_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tap_valid_reg <= 1'b0;
            dr_reg        <= '0;
            dc_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.reg_index == fsu_pkg::REG_ROWS)
                    rows_reg <= cfg.reg_data[fsu_pkg::ROWS_W-1:0];
                else if (cfg.reg_index == fsu_pkg::REG_COLS)
                    cols_reg <= cfg.reg_data;
            end
            if (item_fire && item.op == fsu_pkg::OP_SWAP)
                cur_bank_reg <= !cur_bank_reg;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            if (item_fire)
            begin
                dr_reg        <= '0;
                dc_reg        <= '0;
                tap_valid_reg <= 1'b0;
            end
            else if (state_reg == ST_NB)
            begin
                tap_valid_reg <= nb_valid;
                if (dc_reg == 2'd2)
                begin
                    dc_reg <= '0;
                    dr_reg <= dr_reg + 2'd1;
                end
                else
                begin
                    dc_reg <= dc_reg + 2'd1;
                end
            end
            else
            begin
                tap_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            r_reg      <= item.row;
            c_reg      <= item.col;
            wv_reg     <= wv_sat;
            noise_reg  <= item.noise;
            inside_reg <= in_frame;
            sum_reg    <= '0;
            res_reg    <= (item.op == fsu_pkg::OP_WRITE) ? wv_sat : '0;
        end
        else
        begin
            if (tap_valid_reg)
                sum_reg <= sum_reg + tap_prod;
            if (state_reg == ST_RDW)
                res_reg <= ram_rdata;
            else if (state_reg == ST_CALC)
                res_reg <= calc_value;
        end
        if (state_reg == ST_NB)
            tap_w_reg <= fsu_pkg::fsu_weight(dr_reg, dc_reg);
        if (out_load)
            cell_value_reg <= res_reg;
    end

    fsu_ram #(
        .WIDTH (fsu_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    `FSU_ASSERT_NEXT(a_bank_swap_only, clk, rst_n, !(item_fire && item.op == fsu_pkg::OP_SWAP), $stable(cur_bank_reg), "bank changed without a swap")
    `FSU_ASSERT_NEXT(a_fin_hold, clk, rst_n, state_reg == ST_FIN && out_valid_reg && !result.ready, state_reg == ST_FIN && $stable(res_reg), "pending result lost under stall")
    `FSU_ASSERT_NOW(a_we_states, clk, rst_n, ram_we, state_reg == ST_CLEAR || state_reg == ST_WR || state_reg == ST_CALC, "frame RAM written outside a write phase")
    `FSU_ASSERT_NEXT(a_out_from_fin, clk, rst_n, state_reg != ST_FIN && !out_valid_reg, !out_valid_reg, "result raised outside finish")

endmodule

`default_nettype wire
